@@ rtl/core/nth_substring_finder_assert.svh @@
// assertion macros used by the port-level checker nsf_checker
// depends on a clk and rst signal in the scope of use
`ifndef NTH_SUBSTRING_FINDER_ASSERT_SVH
`define NTH_SUBSTRING_FINDER_ASSERT_SVH

// checked while out of reset
`define NSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define NSF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/nsf_pkg.sv @@
// types and constants of the nth substring finder
// no dependencies
`default_nettype none
package nsf_pkg;

  localparam int CHAR_W    = 8;
  localparam int PATTERN_W = 64;
  localparam int LEN_W     = 4;
  localparam int WANT_W    = 16;
  localparam int POS_OUT_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OCCURRENCE_WANTED = 2'd2;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic                 found;
    logic [POS_OUT_W-1:0] start_position;
    logic                 position_saturated;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/nsf_cell.sv @@
// one window cell: holds one text byte and compares its candidate byte
// with the pattern byte that lines up with it; uses nsf_pkg
`default_nettype none
module nsf_cell #(
  parameter int IDX = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  nsf_pkg::cell_ctrl_t            ctrl,
  input  logic [nsf_pkg::CHAR_W-1:0]     byte_in,
  input  logic [nsf_pkg::PATTERN_W-1:0]  pattern,
  input  logic [nsf_pkg::LEN_W-1:0]      pat_len,
  output logic [nsf_pkg::CHAR_W-1:0]     byte_out,
  output logic                           hit
);
  import nsf_pkg::*;

  localparam logic [LEN_W-1:0] K = LEN_W'(IDX);

  logic [LEN_W-1:0]  sel;
  logic [CHAR_W-1:0] pat_byte;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      byte_out <= '0;
    end else if (ctrl.shift) begin
      byte_out <= byte_in;
    end
  end

  // pattern is newest-last, cell index counts back from the newest byte
  always_comb begin
    sel      = pat_len - K - LEN_W'(1);
    pat_byte = pattern[{sel[2:0], 3'b000} +: CHAR_W];
    hit      = (K >= pat_len) || ((byte_in == pat_byte) && (pat_byte != '0));
  end

endmodule
`default_nettype wire

@@ rtl/core/nth_substring_finder.sv @@
// nth substring finder top level: config registers, cell chain, counters
// and a two-entry result queue; uses nsf_pkg and nsf_cell
//
// Usage:
//  - config: cfg_write with cfg_index (0 pattern_bytes, 1 pattern_length,
//    2 occurrence_wanted) and cfg_data; write only while the block is idle.
//  - input channel in_valid/in_ready/char_in carries one text byte per beat;
//    a zero byte ends the string and clears the per-string state.
//  - output channel out_valid/out_ready carries found, start_position and
//    position_saturated: one beat when the wanted occurrence completes, or
//    one not-found beat at the terminator if no result was given yet.
//  - throughput: one byte per cycle while in_ready is high; each byte is
//    matched to the pattern combinationally by MAX_PATTERN window cells.
//  - results: a result is registered into the queue when the byte that
//    causes it is taken.
//  - stall: results wait in a two-entry queue; in_ready drops only while
//    both entries are full.
//  - reset: synchronous, clears the queue, counters and window; registers
//    return to pattern_length 0 and occurrence_wanted 1.
`default_nettype none
module nth_substring_finder #(
  parameter int MAX_PATTERN   = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [nsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nsf_pkg::PATTERN_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [nsf_pkg::CHAR_W-1:0]        char_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic [nsf_pkg::POS_OUT_W-1:0]     start_position,
  output logic                              position_saturated
);
  import nsf_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam int PW = POSITION_BITS + 1;

  logic [PATTERN_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]     pattern_length;
  logic [WANT_W-1:0]    occurrence_wanted;

  logic [POSITION_BITS-1:0] byte_count;
  logic [WANT_W-1:0]        match_count;
  logic                     done_flag;
  logic                     saturated_flag;

  logic [CHAR_W-1:0]      chain [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit;
  cell_ctrl_t             cell_ctrl;

  logic          in_acc, is_term, len_ok, long_enough, matched, last_match;
  logic          sat_next, push, pop;
  logic [PW-1:0] idx_plus, diff;
  logic [47:0]   diff_wide;
  result_t       push_data;

  logic [1:0] cnt;
  result_t    e0, e1;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes     <= '0;
      pattern_length    <= '0;
      occurrence_wanted <= WANT_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_BYTES:     pattern_bytes     <= cfg_data;
        REG_PATTERN_LENGTH:    pattern_length    <= cfg_data[LEN_W-1:0];
        REG_OCCURRENCE_WANTED: occurrence_wanted <= cfg_data[WANT_W-1:0];
        default: ;
      endcase
    end
  end

  // cell chain
  assign chain[0] = char_in;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k < MAX_PATTERN - 1) begin : g_mid
      nsf_cell #(.IDX(k)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .byte_in  (chain[k]),
        .pattern  (pattern_bytes),
        .pat_len  (pattern_length),
        .byte_out (chain[k+1]),
        .hit      (hit[k])
      );
    end else begin : g_last
      nsf_cell #(.IDX(k)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .byte_in  (chain[k]),
        .pattern  (pattern_bytes),
        .pat_len  (pattern_length),
        .byte_out (),
        .hit      (hit[k])
      );
    end
  end

  // match decision
  always_comb begin
    in_acc      = in_valid && in_ready;
    is_term     = (char_in == '0);
    len_ok      = (pattern_length != '0) && (pattern_length <= LEN_W'(MAX_PATTERN)) &&
                  (occurrence_wanted != '0);
    idx_plus    = {1'b0, byte_count} + PW'(1);
    long_enough = idx_plus >= PW'(pattern_length);
    matched     = !is_term && !done_flag && len_ok && long_enough && (&hit);
    last_match  = matched &&
                  (({1'b0, match_count} + 17'd1) == {1'b0, occurrence_wanted});
    sat_next    = saturated_flag || (byte_count == POS_MAX);
    diff        = idx_plus - PW'(pattern_length);
    diff_wide   = 48'(diff);

    cell_ctrl.shift = in_acc && !is_term && !done_flag;
    cell_ctrl.clear = in_acc && is_term;

    push = in_acc && ((is_term && !done_flag) || last_match);
    push_data.found              = !is_term;
    push_data.start_position     = is_term ? '0 : diff_wide[POS_OUT_W-1:0];
    push_data.position_saturated = is_term ? saturated_flag : sat_next;
  end

  // per-string state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      match_count    <= '0;
      done_flag      <= 1'b0;
      saturated_flag <= 1'b0;
    end else if (in_acc) begin
      if (is_term) begin
        byte_count     <= '0;
        match_count    <= '0;
        done_flag      <= 1'b0;
        saturated_flag <= 1'b0;
      end else if (!done_flag) begin
        saturated_flag <= sat_next;
        if (byte_count != POS_MAX) begin
          byte_count <= byte_count + POSITION_BITS'(1);
        end
        if (last_match) begin
          done_flag <= 1'b1;
        end else if (matched) begin
          match_count <= match_count + WANT_W'(1);
        end
      end
    end
  end

  // result queue
  assign pop       = out_valid && out_ready;
  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case (cnt)
        2'd0: if (push) cnt <= 2'd1;
        2'd1: if (push && !pop) cnt <= 2'd2; else if (pop && !push) cnt <= 2'd0;
        2'd2: if (pop) cnt <= 2'd1;
        default: cnt <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cnt)
      2'd0: if (push) e0 <= push_data;
      2'd1: begin
        if (pop && push) e0 <= push_data;
        else if (push) e1 <= push_data;
      end
      2'd2: if (pop) e0 <= e1;
      default: ;
    endcase
  end

  assign found              = e0.found;
  assign start_position     = e0.start_position;
  assign position_saturated = e0.position_saturated;

endmodule
`default_nettype wire

@@ rtl/core/nsf_checker.sv @@
// port-level checker for nth_substring_finder, bound to the top level
// uses nth_substring_finder_assert.svh and nsf_pkg
`default_nettype none
`include "nth_substring_finder_assert.svh"
module nsf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [nsf_pkg::CHAR_W-1:0]    char_in,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          found,
  input logic [nsf_pkg::POS_OUT_W-1:0] start_position,
  input logic                          position_saturated
);
  import nsf_pkg::*;

  `NSF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output beat dropped")
  `NSF_ASSERT(a_notfound_pos, out_valid && !found |-> start_position == '0, "not-found position")
  `NSF_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid after reset")
  `NSF_ASSERT(a_empty_ready, !out_valid |-> in_ready, "input stalled with empty output")

endmodule

bind nth_substring_finder nsf_checker u_nsf_checker (.*);
`default_nettype wire

@@ sim/nth_substring_finder_checker.sv @@
`timescale 1ns / 100ps
// result checker of the nth substring finder: follows register writes and text
// beats, predicts every search result and compares it with the output beats
// depends on nsf_pkg
module nth_substring_finder_checker #(
  parameter int MAX_PATTERN   = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [nsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nsf_pkg::PATTERN_W-1:0] cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [nsf_pkg::CHAR_W-1:0]    char_in,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          found,
  input  logic [nsf_pkg::POS_OUT_W-1:0] start_position,
  input  logic                          position_saturated,
  output int                            mismatches,
  output int                            outstanding,
  output int                            result_count,
  output int                            found_count,
  output int                            saturated_count
);
  import nsf_pkg::*;

  localparam int WIN_W = 8 * (MAX_PATTERN - 1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam int PRINT_LIMIT = 50;

  logic [PATTERN_W-1:0]     pattern;
  logic [LEN_W-1:0]         pattern_len;
  logic [WANT_W-1:0]        wanted;
  logic [WIN_W-1:0]         window;
  logic [POSITION_BITS-1:0] byte_count;
  logic [WANT_W-1:0]        match_count;
  logic                     done;
  logic                     saturated;
  result_t                  search_outcomes [$];

  initial begin
    mismatches = 0;
    outstanding = 0;
    result_count = 0;
    found_count = 0;
    saturated_count = 0;
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("%0t ns: mismatch, %s", $time, what);
  endtask

  task automatic clear_string();
    window = '0;
    byte_count = '0;
    match_count = '0;
    done = 1'b0;
    saturated = 1'b0;
  endtask

  // recent holds the newest bytes, newest in the low byte
  function automatic logic window_hit(input logic [8*MAX_PATTERN-1:0] recent, input int len);
    logic [7:0] text_b;
    logic [7:0] pat_b;
    for (int k = 0; k < len; k++) begin
      text_b = recent[8*k +: 8];
      pat_b = pattern[8*(len-1-k) +: 8];
      if (text_b != pat_b || pat_b == 8'h00) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic advance_search(input logic [CHAR_W-1:0] ch);
    logic [8*MAX_PATTERN-1:0] recent;
    longint unsigned index;
    int len;
    result_t hit;
    len = pattern_len;
    if (ch == '0) begin
      if (!done) begin
        hit.found = 1'b0;
        hit.start_position = '0;
        hit.position_saturated = saturated;
        search_outcomes.push_back(hit);
      end
      clear_string();
    end else if (!done) begin
      index = byte_count;
      if (byte_count == POS_MAX) saturated = 1'b1;
      else byte_count = byte_count + 1'b1;
      recent = {window, ch};
      window = recent[WIN_W-1:0];
      if (len != 0 && len <= MAX_PATTERN && wanted != '0 && index + 1 >= len &&
          window_hit(recent, len)) begin
        if ({1'b0, match_count} + 17'd1 == {1'b0, wanted}) begin
          done = 1'b1;
          hit.found = 1'b1;
          hit.start_position = POS_OUT_W'(index + 1 - len);
          hit.position_saturated = saturated;
          search_outcomes.push_back(hit);
        end else begin
          match_count = match_count + 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    result_t due;
    if (rst) begin
      pattern = '0;
      pattern_len = '0;
      wanted = WANT_W'(1);
      clear_string();
      search_outcomes.delete();
    end else begin
      if (in_valid && in_ready) advance_search(char_in);
      // a write lands after the byte of the same edge
      if (cfg_write) begin
        case (cfg_index)
          REG_PATTERN_BYTES:     pattern = cfg_data;
          REG_PATTERN_LENGTH:    pattern_len = cfg_data[LEN_W-1:0];
          REG_OCCURRENCE_WANTED: wanted = cfg_data[WANT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        result_count++;
        if (found === 1'b1) found_count++;
        if (position_saturated === 1'b1) saturated_count++;
        if (search_outcomes.size() == 0) begin
          report($sformatf("result beat with none due: found %0b position %0d saturated %0b",
                           found, start_position, position_saturated));
        end else begin
          due = search_outcomes.pop_front();
          if (found !== due.found)
            report($sformatf("found %0b, predicted %0b", found, due.found));
          if (start_position !== due.start_position)
            report($sformatf("start_position %0d, predicted %0d", start_position,
                             due.start_position));
          if (position_saturated !== due.position_saturated)
            report($sformatf("position_saturated %0b, predicted %0b", position_saturated,
                             due.position_saturated));
        end
      end
    end
    outstanding <= search_outcomes.size();
  end

endmodule

@@ sim/nth_substring_finder_test.sv @@
`timescale 1ns / 100ps
// testbench top of the nth substring finder: reset, register settings, text
// beats with random gaps and output stalls, and the verdict
// depends on nsf_pkg, the rtl and nth_substring_finder_checker
module nth_substring_finder_test;
  import nsf_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_BEATS = 850;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [CHAR_W-1:0] TERMINATOR = 8'h00;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PATTERN_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CHAR_W-1:0]    char_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 found;
  logic [POS_OUT_W-1:0] start_position;
  logic                 position_saturated;

  int mismatches;
  int outstanding;
  int result_count;
  int found_count;
  int saturated_count;
  int cycle_count = 0;
  int beats_sent = 0;
  int settings_used = 0;
  int stall_left = 0;
  bit steady = 1'b0;
  logic [7:0]           symbols [3];
  logic [PATTERN_W-1:0] pattern_now = '0;
  int                   length_now = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nth_substring_finder uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_in(char_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .start_position(start_position),
    .position_saturated(position_saturated)
  );

  nth_substring_finder_checker u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_in(char_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .start_position(start_position),
    .position_saturated(position_saturated),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .result_count(result_count),
    .found_count(found_count),
    .saturated_count(saturated_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // mostly short, now and then long
  function automatic int pause_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= pause_length();
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [CHAR_W-1:0] ch);
    int gap;
    in_valid <= 1'b1;
    char_in <= ch;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pause_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every pending result is out and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PATTERN_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [PATTERN_W-1:0] pat, input logic [LEN_W-1:0] len,
                           input logic [WANT_W-1:0] want);
    logic [PATTERN_W-1:0] data;
    settle();
    write_reg(REG_PATTERN_BYTES, pat);
    data = {$urandom, $urandom};
    data[LEN_W-1:0] = len;
    write_reg(REG_PATTERN_LENGTH, data);
    data = {$urandom, $urandom};
    data[WANT_W-1:0] = want;
    write_reg(REG_OCCURRENCE_WANTED, data);
    if ($urandom_range(0, 5) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
    cfg_write <= 1'b0;
    pattern_now = pat;
    length_now = len;
    settings_used++;
  endtask

  function automatic logic [PATTERN_W-1:0] fill_unused(input logic [PATTERN_W-1:0] pat,
                                                       input int len);
    logic [PATTERN_W-1:0] filled;
    filled = {$urandom, $urandom};
    for (int k = 0; k < len && k < 8; k++) filled[8*k +: 8] = pat[8*k +: 8];
    return filled;
  endfunction

  task automatic random_setting();
    logic [PATTERN_W-1:0] pat;
    int len;
    int want;
    for (int k = 0; k < 3; k++) symbols[k] = 8'($urandom_range(1, 255));
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
    pat = {$urandom, $urandom};
    for (int k = 0; k < len; k++) pat[8*k +: 8] = symbols[$urandom_range(0, 2)];
    want = $urandom_range(1, 4);
    case ($urandom_range(0, 11))
      0: len = 0;
      1: len = $urandom_range(9, 15);
      2: want = 0;
      3: want = 65535;
      4: pat[8*$urandom_range(0, len - 1) +: 8] = 8'h00;
      default: ;
    endcase
    configure(pat, len[LEN_W-1:0], want[WANT_W-1:0]);
    steady = ($urandom_range(0, 3) == 0);
  endtask

  // mostly text over the pattern's symbols with whole copies of the pattern mixed in
  task automatic random_string();
    int n;
    int r;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 16);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        send_byte(CHAR_W'($urandom_range(1, 255)));
      end else if (r == 1) begin
        for (int j = 0; j < length_now && j < 8; j++) send_byte(pattern_now[8*j +: 8]);
      end else begin
        send_byte(symbols[$urandom_range(0, 2)]);
      end
    end
    send_byte(TERMINATOR);
  endtask

  initial begin
    int stop_at;
    logic [PATTERN_W-1:0] wide;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // registers as they come out of reset
    send_byte(TERMINATOR);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(TERMINATOR);

    // overlapping occurrences, bytes after a hit are dropped
    configure(fill_unused(64'h6161, 2), 2, 2);
    send_byte(8'h61);
    send_byte(8'h61);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(TERMINATOR);

    // full-length pattern with extreme byte values
    wide = 64'h55AA_02FE_7F80_01FF;
    configure(wide, 8, 1);
    send_byte(8'h33);
    for (int k = 0; k < 8; k++) send_byte(wide[8*k +: 8]);
    send_byte(TERMINATOR);

    // length beyond the window
    configure(64'h6161_6161_6161_6161, 9, 1);
    send_byte(8'h61);
    send_byte(TERMINATOR);

    // zero byte inside the pattern
    configure(fill_unused(64'h0062, 2), 2, 1);
    send_byte(8'h62);
    send_byte(TERMINATOR);

    // occurrence zero
    configure(fill_unused(64'h61, 1), 1, 0);
    send_byte(8'h61);
    send_byte(TERMINATOR);

    // text shorter than the pattern
    configure(fill_unused(64'h636261, 3), 3, 16'hFFFF);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(TERMINATOR);

    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      random_setting();
      repeat ($urandom_range(2, 6)) random_string();
    end

    settle();
    $display("run covered %0d text beats over %0d register settings", beats_sent,
             settings_used);
    $display("%0d results checked, %0d found, %0d with the position counter stuck",
             result_count, found_count, saturated_count);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
